[src/cab_pkg.sv]
`default_nettype none

package cab_pkg;

    localparam int CAB_ITERATIONS = 4;
    localparam int CAB_TABLE_LEN  = 16;
    localparam int CAB_COORD_W    = 16;
    localparam int CAB_ANGLE_W    = 16;
    localparam int CAB_HEADING_W  = 8;
    localparam logic [CAB_HEADING_W-1:0] CAB_HALF_TURN = 8'h80;

    // Working state of one item as it moves down the iteration pipeline.
    typedef struct packed {
        logic signed [CAB_COORD_W-1:0] x;
        logic signed [CAB_COORD_W-1:0] y;
        logic        [CAB_ANGLE_W-1:0] acc;
        logic                          down;
        logic                          neg_x;
        logic                          neg_y;
    } cab_state_t;

    // Arctangent of 2^-i in units of 65536 per turn.
    function automatic logic [CAB_ANGLE_W-1:0] cab_atan(input int idx);
        logic [CAB_ANGLE_W-1:0] t;
        begin
            case (idx)
                0:       t = 16'd8192;
                1:       t = 16'd4836;
                2:       t = 16'd2555;
                3:       t = 16'd1297;
                4:       t = 16'd651;
                5:       t = 16'd325;
                6:       t = 16'd162;
                7:       t = 16'd81;
                8:       t = 16'd40;
                9:       t = 16'd20;
                10:      t = 16'd10;
                11:      t = 16'd5;
                12:      t = 16'd2;
                13:      t = 16'd1;
                default: t = 16'd0;
            endcase
            return t;
        end
    endfunction

    // Clamp a 17-bit sum to the signed 16-bit range.
    function automatic logic signed [CAB_COORD_W-1:0] cab_sat(
        input logic signed [CAB_COORD_W:0] v
    );
        logic signed [CAB_COORD_W-1:0] r;
        begin
            if (v[CAB_COORD_W] != v[CAB_COORD_W-1])
            begin
                r = v[CAB_COORD_W] ? {1'b1, {(CAB_COORD_W-1){1'b0}}}
                                   : {1'b0, {(CAB_COORD_W-1){1'b1}}};
            end
            else
            begin
                r = v[CAB_COORD_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[src/cab_stage.sv]
`default_nettype none

module cab_stage #(
    parameter int STEP = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      advance,
    input  wire                      valid_in,
    input  wire cab_pkg::cab_state_t state_in,
    output logic                     valid_out,
    output cab_pkg::cab_state_t      state_out
);
    import cab_pkg::*;

    localparam logic [CAB_ANGLE_W-1:0] ANGLE_STEP = cab_atan(STEP);

    logic                          valid_reg;
    cab_state_t                    state_reg;
    cab_state_t                    state_next;
    logic signed [CAB_COORD_W-1:0] x_shift;
    logic signed [CAB_COORD_W-1:0] y_shift;
    logic signed [CAB_COORD_W:0]   x_sum;
    logic signed [CAB_COORD_W:0]   y_sum;

    // One vectoring step; an item whose y is already zero passes unchanged.
    always_comb
    begin
        x_shift    = state_in.x >>> STEP;
        y_shift    = state_in.y >>> STEP;
        state_next = state_in;
        if (state_in.down)
        begin
            x_sum = {state_in.x[CAB_COORD_W-1], state_in.x} + {y_shift[CAB_COORD_W-1], y_shift};
            y_sum = {state_in.y[CAB_COORD_W-1], state_in.y} - {x_shift[CAB_COORD_W-1], x_shift};
        end
        else
        begin
            x_sum = {state_in.x[CAB_COORD_W-1], state_in.x} - {y_shift[CAB_COORD_W-1], y_shift};
            y_sum = {state_in.y[CAB_COORD_W-1], state_in.y} + {x_shift[CAB_COORD_W-1], x_shift};
        end
        if (state_in.y != '0)
        begin
            state_next.x    = cab_sat(x_sum);
            state_next.y    = cab_sat(y_sum);
            state_next.acc  = state_in.down ? state_in.acc + ANGLE_STEP
                                            : state_in.acc - ANGLE_STEP;
            state_next.down = ~state_next.y[CAB_COORD_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

`default_nettype wire

[src/cordic_atan2_binary_angle.sv]
// Heading of the vector between two points, as a binary angle of 256 units
// per full turn, found by CORDIC vectoring.
//
// Input channel: in_valid / in_ready carry one beat holding from_x, from_y,
// to_x and to_y. Output channel: out_valid / out_ready carry one beat holding
// heading. Every input beat gives exactly one output beat, in order.
//
// The pipeline has ITERATIONS + 2 register stages: a front stage forms the
// halved differences and their magnitudes, one stage per CORDIC iteration
// does a shift and a saturating add, and a last stage folds the angle into
// its quadrant. A new beat can be accepted in every cycle in which the
// pipeline is not held by a stalled receiver.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready goes low in the same cycle; nothing is lost or repeated, and
// the pipeline resumes as soon as out_ready returns. Reset clears all valid
// bits, so the block comes out of reset empty and ready.
`default_nettype none

module cordic_atan2_binary_angle #(
    parameter int ITERATIONS = cab_pkg::CAB_ITERATIONS
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire signed [cab_pkg::CAB_COORD_W-1:0]   from_x,
    input  wire signed [cab_pkg::CAB_COORD_W-1:0]   from_y,
    input  wire signed [cab_pkg::CAB_COORD_W-1:0]   to_x,
    input  wire signed [cab_pkg::CAB_COORD_W-1:0]   to_y,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic [cab_pkg::CAB_HEADING_W-1:0]       heading
);
    import cab_pkg::*;

    // The pipeline moves as one: it advances whenever the output register is
    // empty or its beat is being taken.
    logic advance;

    logic                          front_valid_reg;
    cab_state_t                    front_reg;
    cab_state_t                    front_next;
    logic signed [CAB_COORD_W-1:0] dx;
    logic signed [CAB_COORD_W-1:0] dy;

    logic       pipe_valid [0:ITERATIONS];
    cab_state_t pipe_state [0:ITERATIONS];

    logic                     out_valid_reg;
    logic [CAB_HEADING_W-1:0] heading_reg;
    logic [CAB_HEADING_W-1:0] heading_next;
    logic [CAB_HEADING_W-1:0] coarse;
    cab_state_t               last;

    assign advance  = ~out_valid_reg | out_ready;
    assign in_ready = advance;

    // Front stage: halve each coordinate (rounding toward minus infinity),
    // take the differences and their magnitudes. The differences stay within
    // -32767..32767, so the magnitudes fit the signed coordinate width.
    always_comb
    begin
        dx               = (from_x >>> 1) - (to_x >>> 1);
        dy               = (from_y >>> 1) - (to_y >>> 1);
        front_next.x     = dx[CAB_COORD_W-1] ? -dx : dx;
        front_next.y     = dy[CAB_COORD_W-1] ? -dy : dy;
        front_next.acc   = '0;
        front_next.down  = 1'b1;
        front_next.neg_x = dx[CAB_COORD_W-1];
        front_next.neg_y = dy[CAB_COORD_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    assign pipe_valid[0] = front_valid_reg;
    assign pipe_state[0] = front_reg;

    // One registered stage per CORDIC iteration.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        cab_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (pipe_valid[i]),
            .state_in  (pipe_state[i]),
            .valid_out (pipe_valid[i+1]),
            .state_out (pipe_state[i+1])
        );
    end

    // Output stage: keep the top byte of the angle and fold it into the
    // quadrant given by the signs of the differences.
    always_comb
    begin
        last   = pipe_state[ITERATIONS];
        coarse = last.acc[CAB_ANGLE_W-1 -: CAB_HEADING_W];
        if (last.neg_x && last.neg_y)
        begin
            heading_next = coarse - CAB_HALF_TURN;
        end
        else if (last.neg_x)
        begin
            heading_next = CAB_HALF_TURN - coarse;
        end
        else if (last.neg_y)
        begin
            heading_next = '0 - coarse;
        end
        else
        begin
            heading_next = coarse;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= pipe_valid[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cab_pkg::*;

    // Run length and flow control.
    localparam int DIRECTED_LAST   = 22;
    localparam int RANDOM_PER_MIX  = 376;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = CAB_ITERATIONS + 8;

    // Arctangent of 2^-i, 65536 units per turn, entry i in bits [16*i +: 16].
    // Entries past the end of the table count as zero.
    localparam logic [16*16-1:0] ATAN_TURNS = {
        16'd0,    16'd0,    16'd1,    16'd2,
        16'd5,    16'd10,   16'd20,   16'd40,
        16'd81,   16'd162,  16'd325,  16'd651,
        16'd1297, 16'd2555, 16'd4836, 16'd8192
    };

    typedef logic signed [CAB_COORD_W-1:0] coord_t;
    typedef logic [CAB_HEADING_W-1:0]      heading_t;

    // One accepted point pair together with the heading it must produce.
    typedef struct {
        coord_t   fx;
        coord_t   fy;
        coord_t   tx;
        coord_t   ty;
        heading_t heading;
    } point_pair_t;

    // Holds the headings still owed by the block, oldest first, and checks
    // each output beat against the front of that queue.
    class heading_scoreboard;
        point_pair_t owed_headings[$];
        int          points_noted;
        int          headings_checked;
        int          mismatches;

        function new();
            points_noted     = 0;
            headings_checked = 0;
            mismatches       = 0;
        endfunction

        static function int clamp_coord(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // Halved differences, magnitudes, a few CORDIC vectoring steps on
        // the magnitudes, then the quadrant fold on the top 8 angle bits.
        static function heading_t predict_heading(coord_t fx, coord_t fy,
                                                  coord_t tx, coord_t ty);
            int              dx;
            int              dy;
            int              x;
            int              y;
            int              nx;
            int              ny;
            logic [15:0]     turn;
            logic [15:0]     ang;
            bit              down;
            heading_t        a;
            dx   = (int'(fx) >>> 1) - (int'(tx) >>> 1);
            dy   = (int'(fy) >>> 1) - (int'(ty) >>> 1);
            x    = (dx < 0) ? -dx : dx;
            y    = (dy < 0) ? -dy : dy;
            ang  = '0;
            down = 1'b1;
            for (int i = 0; i < CAB_ITERATIONS; i++)
            begin
                // Once y has reached zero the remaining steps are skipped.
                if (y != 0)
                begin
                    turn = (i < CAB_TABLE_LEN) ? ATAN_TURNS[16*i +: 16] : 16'd0;
                    if (down)
                    begin
                        nx  = clamp_coord(x + (y >>> i));
                        ny  = clamp_coord(y - (x >>> i));
                        ang = ang + turn;
                    end
                    else
                    begin
                        nx  = clamp_coord(x - (y >>> i));
                        ny  = clamp_coord(y + (x >>> i));
                        ang = ang - turn;
                    end
                    x    = nx;
                    y    = ny;
                    down = (y >= 0);
                end
            end
            a = ang[15:8];
            if (dx < 0 && dy < 0)
                a = a - CAB_HALF_TURN;
            else if (dx < 0)
                a = CAB_HALF_TURN - a;
            else if (dy < 0)
                a = 8'd0 - a;
            return a;
        endfunction

        function void note_point(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
            point_pair_t p;
            p.fx      = fx;
            p.fy      = fy;
            p.tx      = tx;
            p.ty      = ty;
            p.heading = predict_heading(fx, fy, tx, ty);
            owed_headings.push_back(p);
            points_noted++;
        endfunction

        function void check_heading(heading_t got);
            point_pair_t p;
            if (owed_headings.size() == 0)
            begin
                mismatches++;
                $display("%0t: output beat with no point outstanding: expected none, got %0d",
                         $time, got);
                return;
            end
            p = owed_headings.pop_front();
            headings_checked++;
            if (got !== p.heading)
            begin
                mismatches++;
                $display("%0t: heading mismatch for (%0d,%0d)->(%0d,%0d): expected %0d, got %0d",
                         $time, p.fx, p.fy, p.tx, p.ty, p.heading, got);
            end
        endfunction

        function int outstanding();
            return owed_headings.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    coord_t   from_x;
    coord_t   from_y;
    coord_t   to_x;
    coord_t   to_y;
    logic     out_valid;
    logic     out_ready;
    heading_t heading;

    heading_scoreboard sb;

    // Percent chance per cycle that each side sits idle.
    int send_idle_pct;
    int recv_idle_pct;

    // The main process raises this to ask the output side for one long stall.
    bit stall_request;

    int cycle_count;
    int input_stall_cycles;
    int output_hold_cycles;

    cordic_atan2_binary_angle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .heading   (heading)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d headings outstanding.",
                     cycle_count, sb.outstanding());
            $display("FAILURE");
            $finish;
        end
    end

    // Output side. Every signal is sampled right after the rising edge, so it
    // still holds the value that the edge saw; out_ready is then updated with
    // a nonblocking assignment for the next edge. A long hold, when asked
    // for, is counted down here so that the input side keeps offering beats
    // and the pipeline fills and pushes back on in_ready.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_heading(heading);
            if (stall_request)
            begin
                hold_left     = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                output_hold_cycles++;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. Idle cycles
    // before the beat drop in_valid; back-to-back beats keep it high, so it
    // never gets two assignments in one step.
    task automatic send_point(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        from_x   <= fx;
        from_y   <= fy;
        to_x     <= tx;
        to_y     <= ty;
        do
        begin
            @(posedge clk);
            if (!in_ready)
                input_stall_cycles++;
        end
        while (!in_ready);
        sb.note_point(fx, fy, tx, ty);
    endtask

    // Random point pairs of three kinds: fully random coordinates, nearby
    // points whose small difference still spans every direction, and points
    // placed on an axis or a diagonal from the origin, where the early stop
    // and the quadrant fold boundaries sit.
    task automatic send_random_point();
        coord_t fx;
        coord_t fy;
        coord_t tx;
        coord_t ty;
        int     pick;
        pick = $urandom_range(99);
        fx   = coord_t'($urandom);
        fy   = coord_t'($urandom);
        tx   = coord_t'($urandom);
        ty   = coord_t'($urandom);
        if (pick >= 60 && pick < 85)
        begin
            tx = fx + coord_t'($urandom_range(128) - 64);
            ty = fy + coord_t'($urandom_range(128) - 64);
        end
        else if (pick >= 85)
        begin
            tx = '0;
            ty = '0;
            case ($urandom_range(3))
                0: fy = '0;
                1: fx = '0;
                2: fy = fx;
                default: fy = -fx;
            endcase
        end
        send_point(fx, fy, tx, ty);
    endtask

    task automatic run_random_points(int count);
        for (int n = 0; n < count; n++)
            send_random_point();
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        out_ready          = 1'b0;
        from_x             = '0;
        from_y             = '0;
        to_x               = '0;
        to_y               = '0;
        stall_request      = 1'b0;
        cycle_count        = 0;
        input_stall_cycles = 0;
        output_hold_cycles = 0;
        send_idle_pct      = 16;
        recv_idle_pct      = 82;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points. Equal points and points that halve to the same
        // value give the zero vector; the points on the x axis exercise the
        // early stop on the first step; the diagonals hit each branch of the
        // quadrant fold; the corners of the coordinate range drive the widest
        // differences and make the x update saturate.
        send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd1234, -16'sd567, 16'sd1234, -16'sd567);
        send_point(16'sd1, 16'sd1, 16'sd0, 16'sd0);
        send_point(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
        send_point(16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        send_point(-16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd1000, 16'sd0, 16'sd0);
        send_point(16'sd0, -16'sd1000, 16'sd0, 16'sd0);
        send_point(16'sd100, 16'sd100, 16'sd0, 16'sd0);
        send_point(-16'sd100, 16'sd100, 16'sd0, 16'sd0);
        send_point(-16'sd100, -16'sd100, 16'sd0, 16'sd0);
        send_point(16'sd100, -16'sd100, 16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_point(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_point(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_point(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        send_point(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
        send_point(16'sd30000, 16'sd3, 16'sd0, 16'sd0);
        send_point(16'sd3, 16'sd30000, 16'sd0, 16'sd0);
        send_point(16'sd1000, 16'sd600, 16'sd0, 16'sd0);
        send_point(-16'sd7, 16'sd5, 16'sd9, -16'sd3);

        // First mix: a mostly busy sender against a slow receiver.
        run_random_points(RANDOM_PER_MIX);

        // Second mix: a slow sender against a mostly ready receiver.
        send_idle_pct = 82;
        recv_idle_pct = 16;
        run_random_points(RANDOM_PER_MIX);

        // Third mix: no idling on either side. It opens with one long output
        // stall so the pipeline fills up and has to hold off the input side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        run_random_points(RANDOM_PER_MIX);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d headings from %0d point pairs (%0d directed, rest random) "
                 , sb.headings_checked, sb.points_noted, DIRECTED_LAST);
        $display("under three idle mixes; input held off %0d cycles, output held %0d cycles.",
                 input_stall_cycles, output_hold_cycles);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/cab_pkg.sv
src/cab_stage.sv
src/cordic_atan2_binary_angle.sv
dv/testbench.sv
